// ===== rtl/ckn_pkg.sv =====
// ----------------------------------------------------------------------------
// ckn_pkg
// Shared types, constants and helpers for the color key neighbor fill core.
// ----------------------------------------------------------------------------
package ckn_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int HIST_DEPTH = 2 * MAX_WIDTH + 3;
    localparam int AW         = $clog2(HIST_DEPTH);      // history address bits
    localparam int WW         = 11;                      // width register bits
    localparam int CW         = $clog2(MAX_WIDTH);       // column bits
    localparam int TW         = 12;                      // frame tag bits
    localparam int SW         = 11;                      // channel sum bits
    localparam int DIV_STEPS  = SW;

    // configuration register indexes
    localparam logic [2:0] REG_WIDTH     = 3'd0;
    localparam logic [2:0] REG_KEY_RED   = 3'd1;
    localparam logic [2:0] REG_KEY_GREEN = 3'd2;
    localparam logic [2:0] REG_KEY_BLUE  = 3'd3;
    localparam logic [2:0] REG_KEY_ALPHA = 3'd4;

    // window read steps: center first, then the eight neighbors
    localparam logic [3:0] STEP_CENTER      = 4'd0;
    localparam logic [3:0] STEP_UPPER_LEFT  = 4'd1;
    localparam logic [3:0] STEP_LEFT        = 4'd2;
    localparam logic [3:0] STEP_LOWER_LEFT  = 4'd3;
    localparam logic [3:0] STEP_ABOVE       = 4'd4;
    localparam logic [3:0] STEP_BELOW       = 4'd5;
    localparam logic [3:0] STEP_LOWER_RIGHT = 4'd6;
    localparam logic [3:0] STEP_RIGHT       = 4'd7;
    localparam logic [3:0] STEP_UPPER_RIGHT = 4'd8;
    localparam logic [3:0] STEP_LAST        = STEP_UPPER_RIGHT;

    typedef struct packed {
        logic          present;
        logic          first;
        logic [TW-1:0] tag;
        logic [CW-1:0] col;
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
        logic [7:0]    alpha;
    } t_slot;

    typedef struct packed {
        logic       push;
        logic       rd;
        logic       ev_center;
        logic       ev_nb;
        logic       div_init;
        logic       div_step;
        logic       load_out;
        logic [3:0] step;
    } t_cmd;

    typedef struct packed {
        logic center_ok;
        logic center_key;
        logic out_free;
    } t_sts;

    // distance back in the history for a given read step
    function automatic logic [AW-1:0] step_offset(input logic [3:0] step,
                                                  input logic [WW-1:0] w);
        logic [AW-1:0] wx;
        logic [AW-1:0] r;
        wx = AW'(w);
        case (step)
            STEP_CENTER:      r = wx + AW'(1);
            STEP_UPPER_LEFT:  r = (wx << 1) + AW'(2);
            STEP_LEFT:        r = wx + AW'(2);
            STEP_LOWER_LEFT:  r = AW'(2);
            STEP_ABOVE:       r = (wx << 1) + AW'(1);
            STEP_BELOW:       r = AW'(1);
            STEP_LOWER_RIGHT: r = '0;
            STEP_RIGHT:       r = wx;
            STEP_UPPER_RIGHT: r = wx << 1;
            default:          r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/color_key_neighbor_fill_core.sv =====
// ----------------------------------------------------------------------------
// color_key_neighbor_fill_core
// Replaces key-colored pixels by the RGB mean of their valid 3x3 neighbors, alpha zero.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata (low bit up)            | tuser (low bit up)
//  s_axis    | in        | red, green, blue, alpha       | op, frame_first
//  m_axis    | out       | red, green, blue, alpha       | frame_first
//  cfg       | in        | index 0 width, 1..4 key r/g/b/a (no read-back)
//
//  Non-key center: accept, read, evaluate, out; one item at a time.
//  Absent center (drain or not yet emitted): accept, read, evaluate, no result.
//  Key center: 9 history reads, each read then evaluated, then an 11-step divide.
//  The history memory is single-port and the divider is bit-serial.
//  Output register lets the next item in while a result waits.
//  Synchronous active-low reset; history needs no clearing pass (fill count).
// ----------------------------------------------------------------------------
module color_key_neighbor_fill_core
    import ckn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
    input  logic [1:0]  s_axis_tuser,   // op, frame_first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic [0:0]  m_axis_tuser    // out_frame_first
);

    t_cmd cmd;
    t_sts sts;

    ckn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ckn_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_first (m_axis_tuser[0])
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten");

    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> s_axis_tready && !cmd.rd && !cmd.load_out)
        else $error("push outside idle");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> m_axis_tvalid)
        else $error("loaded result not shown");

endmodule

// ===== rtl/ckn_ctrl.sv =====
// ----------------------------------------------------------------------------
// ckn_ctrl
// Sequencer: accept, window reads, divide, hand-off to the output register.
// ----------------------------------------------------------------------------
module ckn_ctrl
    import ckn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [3:0] r_step, n_step;
    logic [3:0] r_div, n_div;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_div   = r_div;
        o_cmd   = '0;
        o_cmd.step = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.push = 1'b1;
                    n_step     = STEP_CENTER;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                if (r_step == STEP_CENTER) begin
                    o_cmd.ev_center = 1'b1;
                    if (!i_sts.center_ok) begin
                        n_state = S_IDLE;
                    end else if (!i_sts.center_key) begin
                        n_state = S_OUT;
                    end else begin
                        n_step  = r_step + 4'd1;
                        n_state = S_READ;
                    end
                end else begin
                    o_cmd.ev_nb = 1'b1;
                    if (r_step == STEP_LAST) begin
                        n_div   = '0;
                        n_state = S_DIV;
                    end else begin
                        n_step  = r_step + 4'd1;
                        n_state = S_READ;
                    end
                end
                if (r_step == STEP_LAST) begin
                    o_cmd.div_init = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div = r_div + 4'd1;
                if (r_div == 4'(DIV_STEPS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_div   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_div   <= n_div;
        end
    end

endmodule

// ===== rtl/ckn_datapath.sv =====
// ----------------------------------------------------------------------------
// ckn_datapath
// Config registers, pixel history memory, neighbor sums, divider, output reg.
// ----------------------------------------------------------------------------
module ckn_datapath
    import ckn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic [31:0] i_in_data,
    input  logic [1:0]  i_in_user,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_data,
    output logic        o_out_first
);

    logic [WW-1:0] r_width;
    logic [7:0]    r_key_red, r_key_green, r_key_blue, r_key_alpha;
    logic [AW-1:0] r_newest;
    logic [AW:0]   r_fill;
    logic [CW-1:0] r_col;
    logic [TW-1:0] r_tag;

    t_slot         mem [HIST_DEPTH];
    t_slot         r_q;
    logic          r_q_ok;

    t_slot         r_c;
    logic          r_c_key;
    logic [SW-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic [3:0]    r_cnt;
    logic [3:0]    r_rem_r, r_rem_g, r_rem_b;

    logic          r_out_valid;
    logic [31:0]   r_out_data;
    logic          r_out_first;

    logic [WW-1:0] w_eff;
    logic [AW-1:0] n_newest;
    t_slot         n_item;
    logic [CW-1:0] col_use;
    logic [WW-1:0] col_inc;
    logic [TW-1:0] tag_use;
    logic [AW-1:0] rd_off;
    logic [AW:0]   rd_sum;
    logic [AW-1:0] rd_addr;
    logic          rd_gate;
    logic          q_key;
    logic          nb_use;

    function automatic logic div_bit(input logic [3:0] rem, input logic nb,
                                     input logic [3:0] d);
        logic [4:0] t;
        t = {rem, nb};
        return (t >= {1'b0, d});
    endfunction

    function automatic logic [3:0] div_rem(input logic [3:0] rem, input logic nb,
                                           input logic [3:0] d);
        logic [4:0] t;
        t = {rem, nb};
        return (t >= {1'b0, d}) ? 4'(t - {1'b0, d}) : t[3:0];
    endfunction

    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (r_width > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
    end

    // new item
    always_comb begin
        n_newest = (r_newest == AW'(HIST_DEPTH - 1)) ? '0 : r_newest + AW'(1);
        col_use  = i_in_user[1] ? '0 : r_col;
        tag_use  = i_in_user[1] ? r_tag + TW'(1) : r_tag;
        col_inc  = WW'(col_use) + WW'(1);
        n_item         = '0;
        n_item.present = !i_in_user[0];
        n_item.first   = i_in_user[1];
        n_item.tag     = tag_use;
        n_item.col     = col_use;
        n_item.red     = i_in_data[7:0];
        n_item.green   = i_in_data[15:8];
        n_item.blue    = i_in_data[23:16];
        n_item.alpha   = i_in_data[31:24];
    end

    // history read address and gating
    always_comb begin
        rd_off  = step_offset(i_cmd.step, w_eff);
        rd_sum  = {1'b0, r_newest} + (AW + 1)'(HIST_DEPTH) - {1'b0, rd_off};
        rd_addr = (rd_sum >= (AW + 1)'(HIST_DEPTH)) ?
                  AW'(rd_sum - (AW + 1)'(HIST_DEPTH)) : AW'(rd_sum);
        case (i_cmd.step)
            STEP_UPPER_LEFT, STEP_LEFT, STEP_LOWER_LEFT:
                rd_gate = (r_c.col != '0);
            STEP_LOWER_RIGHT, STEP_RIGHT, STEP_UPPER_RIGHT:
                rd_gate = ((WW'(r_c.col) + WW'(1)) != w_eff);
            default:
                rd_gate = 1'b1;
        endcase
    end

    assign q_key = (r_q.red == r_key_red) && (r_q.green == r_key_green) &&
                   (r_q.blue == r_key_blue) && (r_q.alpha == r_key_alpha);
    assign nb_use = r_q_ok && r_q.present && (r_q.tag == r_c.tag) && !q_key &&
                    (r_q.alpha != 8'd0);

    assign o_sts.center_ok  = r_q_ok && r_q.present;
    assign o_sts.center_key = q_key;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[n_newest] <= n_item;
        end
        if (i_cmd.rd) begin
            r_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WW'(1024);
            r_key_red   <= '0;
            r_key_green <= '0;
            r_key_blue  <= '0;
            r_key_alpha <= '0;
            r_newest    <= '0;
            r_fill      <= '0;
            r_col       <= '0;
            r_tag       <= '0;
            r_q_ok      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WIDTH:     r_width     <= i_cfg_data;
                    REG_KEY_RED:   r_key_red   <= i_cfg_data[7:0];
                    REG_KEY_GREEN: r_key_green <= i_cfg_data[7:0];
                    REG_KEY_BLUE:  r_key_blue  <= i_cfg_data[7:0];
                    REG_KEY_ALPHA: r_key_alpha <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.push) begin
                r_newest <= n_newest;
                if (r_fill != (AW + 1)'(HIST_DEPTH)) begin
                    r_fill <= r_fill + (AW + 1)'(1);
                end
                if (!i_in_user[0]) begin
                    r_tag <= tag_use;
                    r_col <= (col_inc >= w_eff) ? '0 : CW'(col_inc);
                end
            end
            if (i_cmd.rd) begin
                // entries never written count as absent
                r_q_ok <= ({1'b0, rd_off} < r_fill) && rd_gate;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // center capture, neighbor sums, restoring divide (quotient shifts into sums)
    always_ff @(posedge i_clk) begin
        if (i_cmd.ev_center) begin
            r_c     <= r_q;
            r_c_key <= q_key;
            r_sum_r <= '0;
            r_sum_g <= '0;
            r_sum_b <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.ev_nb && nb_use) begin
            r_sum_r <= r_sum_r + SW'(r_q.red);
            r_sum_g <= r_sum_g + SW'(r_q.green);
            r_sum_b <= r_sum_b + SW'(r_q.blue);
            r_cnt   <= r_cnt + 4'd1;
        end else if (i_cmd.div_step) begin
            r_rem_r <= div_rem(r_rem_r, r_sum_r[SW-1], r_cnt);
            r_rem_g <= div_rem(r_rem_g, r_sum_g[SW-1], r_cnt);
            r_rem_b <= div_rem(r_rem_b, r_sum_b[SW-1], r_cnt);
            r_sum_r <= {r_sum_r[SW-2:0], div_bit(r_rem_r, r_sum_r[SW-1], r_cnt)};
            r_sum_g <= {r_sum_g[SW-2:0], div_bit(r_rem_g, r_sum_g[SW-1], r_cnt)};
            r_sum_b <= {r_sum_b[SW-2:0], div_bit(r_rem_b, r_sum_b[SW-1], r_cnt)};
        end
        // the last neighbor lands together with divider init
        if (i_cmd.div_init) begin
            r_rem_r <= '0;
            r_rem_g <= '0;
            r_rem_b <= '0;
        end
        if (i_cmd.load_out) begin
            r_out_first <= r_c.first;
            if (!r_c_key) begin
                r_out_data <= {r_c.alpha, r_c.blue, r_c.green, r_c.red};
            end else if (r_cnt == 4'd0) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {8'd0, r_sum_b[7:0], r_sum_g[7:0], r_sum_r[7:0]};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_first = r_out_first;

endmodule

// ===== tb/tb_color_key_neighbor_fill_core.sv =====
// ----------------------------------------------------------------------------
// tb_color_key_neighbor_fill_core
// Drives RGBA frames through the color key fill core. Frames are streamed with
// drain items, mixed with broken frames and noise. A cycle-free model predicts
// each finished pixel from a history of accepted items. Every result is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_color_key_neighbor_fill_core;
    import ckn_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 80;

    typedef enum bit {OP_PIXEL = 1'b0, OP_DRAIN = 1'b1} t_op;

    typedef struct {
        bit          present;
        bit          first;
        int unsigned tag;
        int unsigned col;
        bit [7:0]    red, green, blue, alpha;
    } t_hist;

    typedef struct {
        bit [7:0] red, green, blue, alpha;
        bit       first;
    } t_pix_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // red, green, blue, alpha
    logic [1:0]  s_axis_tuser = '0;    // op, frame_first
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // red, green, blue, alpha
    logic [0:0]  m_axis_tuser;         // frame_first

    color_key_neighbor_fill_core dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    t_hist       pix_hist[HIST_DEPTH];
    int unsigned hist_head = 0;
    int unsigned next_col = 0;
    int unsigned frame_no = 0;
    bit [10:0]   width_reg = 11'd1024;
    bit [7:0]    key_r = 0, key_g = 0, key_b = 0, key_a = 0;

    t_pix_out    pending_pix[$];
    int          errors = 0;
    int          src_idle = 0, snk_idle = 0;
    int          idle_cycles = 0;
    int          pixels_sent = 0;

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic t_hist hist_ago(int unsigned k);
        return pix_hist[(hist_head + HIST_DEPTH - k) % HIST_DEPTH];
    endfunction

    function automatic bit matches_key(t_hist s);
        return s.red == key_r && s.green == key_g && s.blue == key_b && s.alpha == key_a;
    endfunction

    // folds one neighbor into the channel sums
    task automatic add_neighbor(input t_hist n, input int unsigned tag, inout int unsigned cnt,
                                inout int unsigned sr, inout int unsigned sg,
                                inout int unsigned sb);
        if (n.present && n.tag == tag && !matches_key(n) && n.alpha != 0) begin
            cnt++;
            sr += n.red;
            sg += n.green;
            sb += n.blue;
        end
    endtask

    task automatic predict_fill(input t_op op, input bit ff, input bit [31:0] px);
        int unsigned w;
        t_hist       it, c;
        t_pix_out    o;
        int unsigned cnt, sr, sg, sb;
        w = eff_width();
        it = '{default: 0};
        if (op == OP_PIXEL) begin
            if (ff) begin
                frame_no++;
                next_col = 0;
            end
            it.present = 1;
            it.first = ff;
            it.tag = frame_no;
            it.col = next_col;
            {it.alpha, it.blue, it.green, it.red} = px;
            next_col = (next_col + 1 >= w) ? 0 : next_col + 1;
        end
        hist_head = (hist_head + 1) % HIST_DEPTH;
        pix_hist[hist_head] = it;
        c = hist_ago(w + 1);
        if (!c.present) return;
        o.red = c.red;
        o.green = c.green;
        o.blue = c.blue;
        o.alpha = c.alpha;
        o.first = c.first;
        if (matches_key(c)) begin
            cnt = 0; sr = 0; sg = 0; sb = 0;
            if (c.col != 0) begin
                add_neighbor(hist_ago(2 * w + 2), c.tag, cnt, sr, sg, sb);
                add_neighbor(hist_ago(w + 2), c.tag, cnt, sr, sg, sb);
                add_neighbor(hist_ago(2), c.tag, cnt, sr, sg, sb);
            end
            add_neighbor(hist_ago(2 * w + 1), c.tag, cnt, sr, sg, sb);
            add_neighbor(hist_ago(1), c.tag, cnt, sr, sg, sb);
            if (c.col + 1 != w) begin
                add_neighbor(hist_ago(0), c.tag, cnt, sr, sg, sb);
                add_neighbor(hist_ago(w), c.tag, cnt, sr, sg, sb);
                add_neighbor(hist_ago(2 * w), c.tag, cnt, sr, sg, sb);
            end
            o.alpha = 0;
            o.red = (cnt != 0) ? 8'(sr / cnt) : 8'd0;
            o.green = (cnt != 0) ? 8'(sg / cnt) : 8'd0;
            o.blue = (cnt != 0) ? 8'(sb / cnt) : 8'd0;
        end
        pending_pix.push_back(o);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_pix_out w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pix.size() == 0) begin
                report_mismatch("unexpected item", m_axis_tdata, 0);
            end else begin
                w = pending_pix.pop_front();
                if (m_axis_tdata[7:0] != w.red)     report_mismatch("red", m_axis_tdata[7:0], w.red);
                if (m_axis_tdata[15:8] != w.green)  report_mismatch("green", m_axis_tdata[15:8], w.green);
                if (m_axis_tdata[23:16] != w.blue)  report_mismatch("blue", m_axis_tdata[23:16], w.blue);
                if (m_axis_tdata[31:24] != w.alpha) report_mismatch("alpha", m_axis_tdata[31:24], w.alpha);
                if (m_axis_tuser[0] != w.first)     report_mismatch("frame_first", m_axis_tuser[0], w.first);
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("[color_key_neighbor_fill_core] ERROR");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input t_op op, input bit ff, input bit [31:0] px);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        s_axis_tuser <= {ff, op};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_fill(op, ff, px);
        if (op == OP_PIXEL) pixels_sent++;
        @(negedge i_clk);
    endtask

    // pauses the source until every result is out, then lets the core settle
    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        while (pending_pix.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input bit [10:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            REG_WIDTH:     width_reg = val;
            REG_KEY_RED:   key_r = val[7:0];
            REG_KEY_GREEN: key_g = val[7:0];
            REG_KEY_BLUE:  key_b = val[7:0];
            REG_KEY_ALPHA: key_a = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_key(input bit [31:0] k);
        write_reg(REG_KEY_RED, {3'd0, k[7:0]});
        write_reg(REG_KEY_GREEN, {3'd0, k[15:8]});
        write_reg(REG_KEY_BLUE, {3'd0, k[23:16]});
        write_reg(REG_KEY_ALPHA, {3'd0, k[31:24]});
    endtask

    task automatic send_drains(input int n);
        repeat (n) send_item(OP_DRAIN, $urandom_range(1), $urandom());
    endtask

    function automatic bit [31:0] rand_pixel(input int key_pct);
        bit [31:0] p;
        if ($urandom_range(99) < key_pct) return {key_a, key_b, key_g, key_r};
        p = $urandom();
        if ($urandom_range(99) < 15) p[31:24] = 0;
        if ($urandom_range(99) < 10) p = {key_a, key_b, key_g, key_r} ^ (32'h1 << $urandom_range(31));
        return p;
    endfunction

    task automatic send_frame(input int rows, input int key_pct, input bit drained);
        int n;
        n = rows * eff_width();
        for (int i = 0; i < n; i++) send_item(OP_PIXEL, i == 0, rand_pixel(key_pct));
        if (drained) send_drains(eff_width() + 1);
    endtask

    // reset values: width 1024 and an all-zero key, one short row
    task automatic test_reset_defaults();
        send_item(OP_PIXEL, 1'b1, 32'h0);
        send_item(OP_PIXEL, 1'b0, 32'hFF_10_20_30);
        send_item(OP_PIXEL, 1'b0, 32'h0);
        send_drains(1025);
        drain_wait();
    endtask

    // 3x3 frames around a key center, channel extremes and transparent neighbors
    task automatic test_neighbor_mean();
        bit [31:0] k;
        k = 32'h80_FF_00_FF;
        write_reg(REG_WIDTH, 11'd3);
        set_key(k);
        send_item(OP_PIXEL, 1'b1, 32'hFF_FF_FF_FF);
        send_item(OP_PIXEL, 1'b0, k);
        send_item(OP_PIXEL, 1'b0, 32'hFF_00_00_00);
        send_item(OP_PIXEL, 1'b0, 32'h00_FF_FF_FF);   // transparent, skipped
        send_item(OP_PIXEL, 1'b0, k);
        send_item(OP_PIXEL, 1'b0, 32'h01_01_02_03);
        send_item(OP_PIXEL, 1'b0, k);
        send_item(OP_PIXEL, 1'b0, 32'hFF_FF_FF_FE);
        send_item(OP_PIXEL, 1'b0, k);
        // all-key frame: no usable neighbor
        send_item(OP_PIXEL, 1'b1, k);
        send_item(OP_PIXEL, 1'b0, k);
        send_item(OP_PIXEL, 1'b0, k);
        send_drains(4);
        drain_wait();
    endtask

    // width 0 acts as 1, oversize acts as the maximum
    task automatic test_width_limits();
        write_reg(REG_WIDTH, 11'd0);
        set_key(32'h00_00_00_00);
        send_item(OP_PIXEL, 1'b1, 32'h0);
        send_item(OP_PIXEL, 1'b0, 32'h40_40_40_40);
        send_item(OP_PIXEL, 1'b0, 32'h0);
        send_drains(2);
        drain_wait();
        write_reg(REG_WIDTH, 11'd1500);
        send_item(OP_PIXEL, 1'b1, 32'h11_22_33_44);
        send_item(OP_PIXEL, 1'b0, 32'h0);
        send_drains(1025);
        drain_wait();
    endtask

    // new frame before the old one drains, and drains in the middle of a row
    task automatic test_frame_breaks();
        bit [31:0] k;
        k = 32'h7F_00_FF_00;
        write_reg(REG_WIDTH, 11'd2);
        set_key(k);
        send_item(OP_PIXEL, 1'b1, 32'hFF_20_20_20);
        send_item(OP_PIXEL, 1'b0, 32'hFF_40_40_40);
        send_item(OP_PIXEL, 1'b0, k);
        send_item(OP_PIXEL, 1'b1, k);
        send_item(OP_DRAIN, 1'b1, 32'hFF_FF_FF_FF);
        send_item(OP_PIXEL, 1'b0, 32'hFF_60_60_60);
        send_drains(3);
        drain_wait();
    endtask

    task automatic test_random_frames(input int target);
        int stop;
        bit [31:0] k;
        bit dr;
        bit tail_open;
        stop = pixels_sent + target;
        tail_open = 1'b0;
        while (pixels_sent < stop) begin
            if ($urandom_range(99) < 20) begin
                // an undrained frame tail must be pushed out before waiting
                if (tail_open) send_drains(eff_width() + 1);
                tail_open = 1'b0;
                drain_wait();
                k = $urandom();
                if ($urandom_range(3) == 0) k[31:24] = 0;
                set_key(k);
                write_reg(REG_WIDTH, 11'($urandom_range(1, 8)));
            end
            if (eff_width() > 8) begin
                send_frame(1, 30, 1'b1);
                tail_open = 1'b0;
            end else begin
                dr = ($urandom_range(9) != 0);
                send_frame($urandom_range(1, 4), 35, dr);
                tail_open = !dr;
                if ($urandom_range(99) < 5) send_drains($urandom_range(1, 3));
            end
        end
        if (tail_open) send_drains(eff_width() + 1);
        drain_wait();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        src_idle = 24;
        snk_idle = 85;
        test_reset_defaults();
        test_neighbor_mean();
        test_width_limits();
        test_frame_breaks();
        test_random_frames(100);
        src_idle = 85;
        snk_idle = 24;
        test_random_frames(100);
        src_idle = 0;
        snk_idle = 0;
        test_random_frames(100);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("[color_key_neighbor_fill_core] OK");
        end else begin
            $display("[color_key_neighbor_fill_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ckn_pkg.sv
rtl/ckn_ctrl.sv
rtl/ckn_datapath.sv
rtl/color_key_neighbor_fill_core.sv
tb/tb_color_key_neighbor_fill_core.sv
